@@ hdl/tnst_pkg.sv @@
// Package for the top-N score tracker: slot count, index width, stored entry
// layout and operation codes. It depends on nothing else.
package tnst_pkg;

	// Number of tracked slots and the width of a slot index.
	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Widths of the stored fields and of the ranking key.
	localparam int ROW_W   = 12;
	localparam int COL_W   = 12;
	localparam int SCORE_W = 16;
	localparam int KEY_W   = SCORE_W + 1;
	localparam int SLOT_W  = 6;

	// Operation codes of an input beat.
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_OFFER = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// One stored candidate, as kept in the slot memory.
	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [SCORE_W-1:0] score;
	} entry_t;

endpackage

@@ hdl/tnst_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by the top-N score tracker for its slot storage.
module tnst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/top_n_score_tracker_core.sv @@
// Top-N score tracker: keeps the best-scoring candidate blocks seen so far.
// Depends on tnst_pkg and the generic RAM tnst_ram.
//
// Input channel (in_valid/in_ready) carries one operation per beat:
//   clear empties every slot at once and produces no output.
//   offer walks all slots through the slot memory, one slot a cycle, looking
//   for the first slot with the lowest key (empty below any score), and
//   replaces it if it is empty or the candidate score is strictly greater.
//   It produces no output.
//   read emits ENTRIES output beats in slot order, last_slot set on the final
//   one; after a registered memory read it streams one beat a cycle while the
//   receiver keeps out_ready high.
// Operation code 3 is taken and ignored.
// One operation is in work at a time; in_ready is high whenever the block is
// idle, even while an output beat still waits in the output register.
// A stall on out_ready holds the output register and pauses the read walk.
// Reset empties every slot at once through per-slot valid flops and leaves
// the output channel empty; the memory contents need no clearing pass.
module top_n_score_tracker_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [tnst_pkg::ROW_W-1:0]   cand_row,
	input  logic [tnst_pkg::COL_W-1:0]   cand_col,
	input  logic [tnst_pkg::SCORE_W-1:0] cand_score,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tnst_pkg::SLOT_W-1:0]  slot_index,
	output logic                         slot_valid,
	output logic [tnst_pkg::ROW_W-1:0]   slot_row,
	output logic [tnst_pkg::COL_W-1:0]   slot_col,
	output logic [tnst_pkg::SCORE_W-1:0] slot_score,
	output logic                         last_slot
);

	localparam logic [tnst_pkg::IDX_W-1:0] LAST_IDX = tnst_pkg::IDX_W'(tnst_pkg::ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	state_t                         state_q;
	logic [tnst_pkg::ENTRIES-1:0]   entry_valid_q;
	logic [tnst_pkg::IDX_W-1:0]     idx_q;
	logic [tnst_pkg::IDX_W-1:0]     min_idx_q;
	logic [tnst_pkg::KEY_W-1:0]     min_key_q;
	tnst_pkg::entry_t               cand_q;

	// Output register.
	logic                           out_valid_q;
	logic [tnst_pkg::IDX_W-1:0]     out_idx_q;
	logic                           out_ent_valid_q;
	tnst_pkg::entry_t               out_entry_q;
	logic                           out_last_q;

	// Memory ports.
	logic                           rd_en;
	logic [tnst_pkg::IDX_W-1:0]     rd_addr;
	tnst_pkg::entry_t               rd_data;
	logic                           wr_en;

	logic                           in_beat;
	tnst_pkg::op_t                  op;
	logic                           is_last;
	logic                           cur_valid;
	logic [tnst_pkg::KEY_W-1:0]     cur_key;
	logic                           take_cur;
	logic [tnst_pkg::IDX_W-1:0]     best_idx;
	logic [tnst_pkg::KEY_W-1:0]     best_key;
	logic [tnst_pkg::KEY_W-1:0]     cand_key;
	logic                           out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign op        = tnst_pkg::op_t'(operation);
	assign is_last   = (idx_q == LAST_IDX);
	assign out_free  = !out_valid_q || out_ready;
	assign cur_valid = entry_valid_q[idx_q];

	// Ranking of the slot whose data has just come out of the memory.
	assign cur_key  = cur_valid ? ({1'b0, rd_data.score} + tnst_pkg::KEY_W'(1))
	                            : '0;
	assign take_cur = (idx_q == '0) || (cur_key < min_key_q);
	assign best_idx = take_cur ? idx_q : min_idx_q;
	assign best_key = take_cur ? cur_key : min_key_q;
	assign cand_key = {1'b0, cand_q.score} + tnst_pkg::KEY_W'(1);

	// Memory control: walk from slot zero, one slot a cycle while not stalled.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_en = in_beat && (op == tnst_pkg::OP_OFFER || op == tnst_pkg::OP_READ);
			end
			ST_SCAN: begin
				rd_en   = !is_last;
				rd_addr = idx_q + tnst_pkg::IDX_W'(1);
				wr_en   = is_last && ((best_key == '0) || (cand_key > best_key));
			end
			ST_READ: begin
				rd_en   = out_free && !is_last;
				rd_addr = idx_q + tnst_pkg::IDX_W'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	tnst_ram #(
		.WIDTH($bits(tnst_pkg::entry_t)),
		.DEPTH(tnst_pkg::ENTRIES)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (best_idx),
		.wr_data (cand_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer, slot valid flags and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			entry_valid_q   <= '0;
			out_valid_q     <= 1'b0;
			idx_q           <= '0;
			min_idx_q       <= '0;
			min_key_q       <= '0;
			cand_q          <= '0;
			out_idx_q       <= '0;
			out_ent_valid_q <= 1'b0;
			out_entry_q     <= '0;
			out_last_q      <= 1'b0;
		end else begin
			// A taken beat empties the output register unless the read walk refills it.
			if (out_valid_q && out_ready && (state_q != ST_READ)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						idx_q <= '0;
						unique case (op)
							tnst_pkg::OP_CLEAR: begin
								entry_valid_q <= '0;
							end
							tnst_pkg::OP_OFFER: begin
								cand_q.row   <= cand_row;
								cand_q.col   <= cand_col;
								cand_q.score <= cand_score;
								state_q      <= ST_SCAN;
							end
							tnst_pkg::OP_READ: begin
								state_q <= ST_READ;
							end
							tnst_pkg::OP_NONE: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					min_idx_q <= best_idx;
					min_key_q <= best_key;
					if (is_last) begin
						if (wr_en) begin
							entry_valid_q[best_idx] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + tnst_pkg::IDX_W'(1);
					end
				end
				ST_READ: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						out_idx_q       <= idx_q;
						out_ent_valid_q <= cur_valid;
						out_entry_q     <= cur_valid ? rd_data : '0;
						out_last_q      <= is_last;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + tnst_pkg::IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output beat.
	assign out_valid  = out_valid_q;
	assign slot_index = tnst_pkg::SLOT_W'(out_idx_q);
	assign slot_valid = out_ent_valid_q;
	assign slot_row   = out_entry_q.row;
	assign slot_col   = out_entry_q.col;
	assign slot_score = out_entry_q.score;
	assign last_slot  = out_last_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for top_n_score_tracker_core: directed and random clear, offer and read beats,
// with every read-out beat checked against a slot-level predictor kept in this file.
// Depends on tnst_pkg and the core RTL, which also needs the RAM tnst_ram.
module testbench;

	// Run shape: quiet-cycle limit, settling time at the end, random phases.
	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = 4 * tnst_pkg::ENTRIES + 8;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 54;

	// One operation beat waiting to be sent.
	typedef struct {
		tnst_pkg::op_t                op;
		logic [tnst_pkg::ROW_W-1:0]   row;
		logic [tnst_pkg::COL_W-1:0]   col;
		logic [tnst_pkg::SCORE_W-1:0] score;
		bit                           drain_first;
	} tracker_op_t;

	// One slot report beat as the block should emit it.
	typedef struct {
		logic [tnst_pkg::SLOT_W-1:0]  index;
		logic                         valid;
		logic [tnst_pkg::ROW_W-1:0]   row;
		logic [tnst_pkg::COL_W-1:0]   col;
		logic [tnst_pkg::SCORE_W-1:0] score;
		logic                         last;
	} slot_report_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          in_valid   = 1'b0;
	logic                          in_ready;
	logic [1:0]                    operation  = '0;
	logic [tnst_pkg::ROW_W-1:0]    cand_row   = '0;
	logic [tnst_pkg::COL_W-1:0]    cand_col   = '0;
	logic [tnst_pkg::SCORE_W-1:0]  cand_score = '0;
	logic                          out_valid;
	logic                          out_ready  = 1'b0;
	logic [tnst_pkg::SLOT_W-1:0]   slot_index;
	logic                          slot_valid;
	logic [tnst_pkg::ROW_W-1:0]    slot_row;
	logic [tnst_pkg::COL_W-1:0]    slot_col;
	logic [tnst_pkg::SCORE_W-1:0]  slot_score;
	logic                          last_slot;

	tracker_op_t  ops_to_send[$];
	slot_report_t slot_reports_due[$];
	tracker_op_t  presented;
	bit           beat_slot_free;
	int           send_idle_pct = 0;
	int           stall_pct     = 0;
	int           mismatch_count = 0;
	int           quiet_cycles   = 0;

	// Predicted slot contents.
	logic                         tracked_valid [tnst_pkg::ENTRIES];
	logic [tnst_pkg::ROW_W-1:0]   tracked_row   [tnst_pkg::ENTRIES];
	logic [tnst_pkg::COL_W-1:0]   tracked_col   [tnst_pkg::ENTRIES];
	logic [tnst_pkg::SCORE_W-1:0] tracked_score [tnst_pkg::ENTRIES];

	top_n_score_tracker_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.cand_row   (cand_row),
		.cand_col   (cand_col),
		.cand_score (cand_score),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_index (slot_index),
		.slot_valid (slot_valid),
		.slot_row   (slot_row),
		.slot_col   (slot_col),
		.slot_score (slot_score),
		.last_slot  (last_slot)
	);

	// Clock with a 2 ns period.
	initial begin
		forever #1 clk = ~clk;
	end

	// Empty every predicted slot, as reset and a clear do.
	task automatic clear_tracked();
		for (int i = 0; i < tnst_pkg::ENTRIES; i++) begin
			tracked_valid[i] = 1'b0;
			tracked_row[i]   = '0;
			tracked_col[i]   = '0;
			tracked_score[i] = '0;
		end
	endtask

	// Ranking key of a slot: an empty slot ranks below any score.
	function automatic logic [tnst_pkg::KEY_W-1:0] rank_of(int slot);
		return tracked_valid[slot]
			? tnst_pkg::KEY_W'(tracked_score[slot]) + tnst_pkg::KEY_W'(1) : '0;
	endfunction

	// Apply one accepted beat to the predicted slots and queue any slot reports.
	task automatic track_operation(input tracker_op_t t);
		int                           pos;
		logic [tnst_pkg::KEY_W-1:0]   lowest;
		slot_report_t                 rep;
		case (t.op)
			tnst_pkg::OP_CLEAR: begin
				clear_tracked();
			end
			tnst_pkg::OP_OFFER: begin
				pos = 0;
				lowest = rank_of(0);
				for (int i = 1; i < tnst_pkg::ENTRIES; i++) begin
					if (rank_of(i) < lowest) begin
						pos = i;
						lowest = rank_of(i);
					end
				end
				if (!tracked_valid[pos] || t.score > tracked_score[pos]) begin
					tracked_valid[pos] = 1'b1;
					tracked_row[pos]   = t.row;
					tracked_col[pos]   = t.col;
					tracked_score[pos] = t.score;
				end
			end
			tnst_pkg::OP_READ: begin
				for (int i = 0; i < tnst_pkg::ENTRIES; i++) begin
					rep.index = tnst_pkg::SLOT_W'(i);
					rep.valid = tracked_valid[i];
					rep.row   = tracked_valid[i] ? tracked_row[i] : '0;
					rep.col   = tracked_valid[i] ? tracked_col[i] : '0;
					rep.score = tracked_valid[i] ? tracked_score[i] : '0;
					rep.last  = (i == tnst_pkg::ENTRIES - 1);
					slot_reports_due.push_back(rep);
				end
			end
			default: begin
			end
		endcase
	endtask

	// Compare one field of a slot report beat; unknown bits count as a mismatch.
	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Check one accepted output beat against the oldest predicted report.
	task automatic check_slot_report();
		slot_report_t rep;
		if (slot_reports_due.size() == 0) begin
			$display("%0t: unexpected beat, expected none, actual slot %0d score %0d",
				$time, slot_index, slot_score);
			mismatch_count++;
		end else begin
			rep = slot_reports_due.pop_front();
			compare_field("slot_index", rep.index, slot_index);
			compare_field("slot_valid", rep.valid, slot_valid);
			compare_field("slot_row", rep.row, slot_row);
			compare_field("slot_col", rep.col, slot_col);
			compare_field("slot_score", rep.score, slot_score);
			compare_field("last_slot", rep.last, last_slot);
		end
	endtask

	// Input driver: predicts each accepted beat, then presents the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			beat_slot_free = !in_valid;
			if (in_valid && in_ready) begin
				track_operation(presented);
				beat_slot_free = 1'b1;
			end
			if (beat_slot_free) begin
				if (ops_to_send.size() != 0
						&& !(ops_to_send[0].drain_first && slot_reports_due.size() != 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					presented = ops_to_send.pop_front();
					in_valid   <= 1'b1;
					operation  <= presented.op;
					cand_row   <= presented.row;
					cand_col   <= presented.col;
					cand_score <= presented.score;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each accepted beat and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_slot_report();
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: too many cycles without any accepted beat ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_op(input tnst_pkg::op_t op, input int unsigned row,
			input int unsigned col, input int unsigned score, input bit drain_first);
		tracker_op_t t;
		t.op          = op;
		t.row         = tnst_pkg::ROW_W'(row);
		t.col         = tnst_pkg::COL_W'(col);
		t.score       = tnst_pkg::SCORE_W'(score);
		t.drain_first = drain_first;
		ops_to_send.push_back(t);
	endtask

	// Score mix: extremes, a narrow band that makes ties likely, and full range.
	function automatic int unsigned pick_score();
		int unsigned sel;
		sel = $urandom_range(9);
		case (sel)
			0: return 0;
			1: return 65535;
			2, 3, 4: return $urandom_range(15);
			default: return $urandom_range(65535);
		endcase
	endfunction

	function automatic int unsigned pick_coord();
		int unsigned sel;
		sel = $urandom_range(15);
		case (sel)
			0: return 0;
			1: return 4095;
			default: return $urandom_range(4095);
		endcase
	endfunction

	// Random beats: mostly offers with reads between them, now and then a clear;
	// ignored codes come on top of the count.
	task automatic queue_random_ops(input int count);
		int             taken;
		int             pick;
		tnst_pkg::op_t  op;
		bit             drain;
		taken = 0;
		drain = 1'b1;
		while (taken < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				op = tnst_pkg::OP_OFFER;
			end else if (pick < 86) begin
				op = tnst_pkg::OP_READ;
			end else if (pick < 92) begin
				op = tnst_pkg::OP_CLEAR;
			end else begin
				op = tnst_pkg::OP_NONE;
			end
			queue_op(op, pick_coord(), pick_coord(), pick_score(), drain);
			drain = 1'b0;
			if (op != tnst_pkg::OP_NONE) begin
				taken++;
			end
		end
	endtask

	// Stimulus and end of run.
	initial begin
		clear_tracked();

		// Directed part: empty read, extremes, fill, ties, equal minima, ignored code, clear.
		queue_op(tnst_pkg::OP_READ, 0, 0, 0, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 0, 0, 0, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 4095, 4095, 65535, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 10, 20, 7, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 11, 21, 7, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 12, 22, 7, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 13, 23, 100, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 14, 24, 200, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 15, 25, 300, 1'b0);
		queue_op(tnst_pkg::OP_READ, 0, 0, 0, 1'b0);
		// A score equal to the lowest stored one does not replace it.
		queue_op(tnst_pkg::OP_OFFER, 1, 1, 0, 1'b0);
		// Replaces slot 0; then four slots share the lowest score.
		queue_op(tnst_pkg::OP_OFFER, 2730, 1365, 7, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 3, 3, 7, 1'b0);
		// The lowest-index equal minimum is the one replaced.
		queue_op(tnst_pkg::OP_OFFER, 1365, 2730, 8, 1'b0);
		queue_op(tnst_pkg::OP_READ, 0, 0, 0, 1'b0);
		queue_op(tnst_pkg::OP_NONE, 4095, 4095, 65535, 1'b0);
		queue_op(tnst_pkg::OP_READ, 0, 0, 0, 1'b0);
		queue_op(tnst_pkg::OP_CLEAR, 4095, 4095, 65535, 1'b0);
		queue_op(tnst_pkg::OP_READ, 0, 0, 0, 1'b0);
		queue_op(tnst_pkg::OP_OFFER, 4095, 0, 43690, 1'b0);
		queue_op(tnst_pkg::OP_READ, 0, 0, 0, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_to_send.size() != 0) @(negedge clk);

		// Random phases: no idling, sender idle, receiver stalling, both.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 83;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 83;
				end
				default: begin
					send_idle_pct = 7;
					stall_pct     = 7;
				end
			endcase
			queue_random_ops(PHASE_ITEMS);
			while (ops_to_send.size() != 0) @(negedge clk);
		end

		// Drain, then give the block time to show any stray beat.
		while (in_valid || slot_reports_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
